>>> rtl/e8d_pkg.sv
// ----------------------------------------------------------------------------
// e8d_pkg
// Shared widths, constants and types of the E8 lattice decoder pipeline.
// ----------------------------------------------------------------------------
package e8d_pkg;

	localparam int DIM       = 8;
	localparam int IDX_W     = $clog2(DIM);
	localparam int FRAC_BITS = 8;
	localparam int IN_W      = 16;
	localparam int OUT_W     = 10;

	localparam int ONE_Q  = 1 << FRAC_BITS;
	localparam int HALF_Q = 1 << (FRAC_BITS - 1);

	// coordinate after the half offset, signed
	localparam int X_W   = IN_W + 2;
	// rounded integer coordinate, signed, with room for the parity fix
	localparam int PT_W  = IN_W - FRAC_BITS + 3;
	// rounding residue r*ONE - x, signed, |d| <= HALF
	localparam int D_W   = FRAC_BITS + 1;
	// unsigned residue magnitude
	localparam int ERR_W = FRAC_BITS;
	// residue after the parity fix, |e| <= ONE + HALF
	localparam int E_W   = FRAC_BITS + 2;
	// one squared residue, unsigned
	localparam int SQ_W  = 2 * FRAC_BITS + 2;
	// sum of DIM squares
	localparam int DS_W  = SQ_W + IDX_W;
	// low coordinate bits that reach the doubled output
	localparam int LO_W  = OUT_W - 1;

	localparam int S_TDATA_W = DIM * IN_W;
	localparam int M_TDATA_W = ((DIM * OUT_W + 7) / 8) * 8;

	// per-stage load enables
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} stage_en_t;

endpackage

>>> rtl/e8d_d8.sv
// ----------------------------------------------------------------------------
// e8d_d8
// D8 decode in two stages: round every coordinate, then fix odd parity.
// ----------------------------------------------------------------------------
module e8d_d8 import e8d_pkg::*; (
	input  logic                    clk,
	input  stage_en_t               en,
	input  logic signed [X_W-1:0]   x [DIM],
	output logic signed [PT_W-1:0]  pt_s2 [DIM],
	output logic signed [E_W-1:0]   e_s2 [DIM]
);

	logic        [X_W-1:0]  mag   [DIM];
	logic        [X_W-1:0]  rnd   [DIM];
	logic signed [PT_W-1:0] r_c   [DIM];
	logic signed [X_W:0]    dfull [DIM];

	logic signed [PT_W-1:0] r_s1 [DIM];
	logic signed [D_W-1:0]  d_s1 [DIM];

	// stage 1: round half away from zero, keep residue r*ONE - x
	always_comb begin
		for (int i = 0; i < DIM; i++) begin
			mag[i]   = x[i][X_W-1] ? $unsigned(-x[i]) : $unsigned(x[i]);
			rnd[i]   = (mag[i] + X_W'(HALF_Q)) >> FRAC_BITS;
			r_c[i]   = x[i][X_W-1] ? -$signed(PT_W'(rnd[i])) : $signed(PT_W'(rnd[i]));
			dfull[i] = $signed({r_c[i], {FRAC_BITS{1'b0}}}) - $signed({x[i][X_W-1], x[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			for (int i = 0; i < DIM; i++) begin
				r_s1[i] <= r_c[i];
				d_s1[i] <= dfull[i][D_W-1:0];
			end
		end
	end

	// stage 2: worst coordinate (first on tie) and parity fix
	logic [ERR_W-1:0] err  [DIM];
	logic [ERR_W-1:0] err1 [DIM/2];
	logic [IDX_W-1:0] idx1 [DIM/2];
	logic [ERR_W-1:0] err2 [DIM/4];
	logic [IDX_W-1:0] idx2 [DIM/4];
	logic [IDX_W-1:0] best;
	logic             odd;
	logic signed [PT_W-1:0] pt_c [DIM];
	logic signed [E_W-1:0]  e_c  [DIM];

	always_comb begin
		odd = 1'b0;
		for (int i = 0; i < DIM; i++) begin
			err[i] = d_s1[i][D_W-1] ? ERR_W'(-d_s1[i]) : ERR_W'(d_s1[i]);
			odd    = odd ^ r_s1[i][0];
		end
		for (int j = 0; j < DIM / 2; j++) begin
			if (err[2*j] >= err[2*j+1]) begin
				err1[j] = err[2*j];
				idx1[j] = IDX_W'(2 * j);
			end else begin
				err1[j] = err[2*j+1];
				idx1[j] = IDX_W'(2 * j + 1);
			end
		end
		for (int j = 0; j < DIM / 4; j++) begin
			if (err1[2*j] >= err1[2*j+1]) begin
				err2[j] = err1[2*j];
				idx2[j] = idx1[2*j];
			end else begin
				err2[j] = err1[2*j+1];
				idx2[j] = idx1[2*j+1];
			end
		end
		best = (err2[0] >= err2[1]) ? idx2[0] : idx2[1];
		for (int i = 0; i < DIM; i++) begin
			e_c[i]  = E_W'(d_s1[i]);
			pt_c[i] = r_s1[i];
			if (odd && (best == IDX_W'(i))) begin
				// x above its rounded value: step up, else step down
				if (d_s1[i][D_W-1]) begin
					pt_c[i] = r_s1[i] + PT_W'(1);
					e_c[i]  = E_W'(d_s1[i]) + E_W'(ONE_Q);
				end else begin
					pt_c[i] = r_s1[i] - PT_W'(1);
					e_c[i]  = E_W'(d_s1[i]) - E_W'(ONE_Q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			for (int i = 0; i < DIM; i++) begin
				pt_s2[i] <= pt_c[i];
				e_s2[i]  <= e_c[i];
			end
		end
	end

endmodule

>>> rtl/e8d_dist.sv
// ----------------------------------------------------------------------------
// e8d_dist
// Squared distance of one candidate: square stage, then sum stage.
// ----------------------------------------------------------------------------
module e8d_dist import e8d_pkg::*; (
	input  logic                  clk,
	input  stage_en_t             en,
	input  logic signed [E_W-1:0] e [DIM],
	output logic [DS_W-1:0]       dsum_s4
);

	logic signed [2*E_W-1:0] prod  [DIM];
	logic        [SQ_W-1:0]  sq_s3 [DIM];
	logic        [DS_W-1:0]  acc;

	always_comb begin
		for (int i = 0; i < DIM; i++) begin
			prod[i] = e[i] * e[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			for (int i = 0; i < DIM; i++) begin
				sq_s3[i] <= prod[i][SQ_W-1:0];
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < DIM; i++) begin
			acc = acc + DS_W'(sq_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			dsum_s4 <= acc;
		end
	end

endmodule

>>> rtl/e8_lattice_decoder_top.sv
// ----------------------------------------------------------------------------
// e8_lattice_decoder_top
// Nearest E8 point: two D8 decodes (integer and half-integer coset), distance
// compare, doubled coordinates out.
// ----------------------------------------------------------------------------
//  channel  dir  width  contents (lowest bit first)
//  s_*      in   128    y_0 .. y_7, 16 bits each, signed, FRAC_BITS fraction
//  m_*      out  80+1   tdata: pt2_0 .. pt2_7, 10 bits each; tuser: half_coset
//
//  Five register stages: round, parity fix, square, sum, compare/select.
//  One beat per cycle is sustained while m_tready stays high.
//  Each stage loads when it is empty or the stage after it moves, so bubbles
//  close up and a stall at m_tready backs up without loss.
//  Reset clears only the valid bits; the data path has no reset.
// ----------------------------------------------------------------------------
module e8_lattice_decoder_top import e8d_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // y_0 .. y_7
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // pt2_0 .. pt2_7
	output logic                 m_tuser    // half_coset
);

	stage_en_t en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage enables, ready chain from the output back
	always_comb begin
		en.en_s5 = !vld_s5 || m_tready;
		en.en_s4 = !vld_s4 || en.en_s5;
		en.en_s3 = !vld_s3 || en.en_s4;
		en.en_s2 = !vld_s2 || en.en_s3;
		en.en_s1 = !vld_s1 || en.en_s2;
	end

	assign s_tready = en.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en.en_s1) vld_s1 <= s_tvalid;
			if (en.en_s2) vld_s2 <= vld_s1;
			if (en.en_s3) vld_s3 <= vld_s2;
			if (en.en_s4) vld_s4 <= vld_s3;
			if (en.en_s5) vld_s5 <= vld_s4;
		end
	end

	// unpack; half-integer coset decodes y - 1/2
	logic signed [X_W-1:0] x_int  [DIM];
	logic signed [X_W-1:0] x_half [DIM];

	always_comb begin
		for (int i = 0; i < DIM; i++) begin
			x_int[i]  = X_W'($signed(s_tdata[IN_W*i +: IN_W]));
			x_half[i] = x_int[i] - X_W'(HALF_Q);
		end
	end

	logic signed [PT_W-1:0] pt1_s2 [DIM];
	logic signed [PT_W-1:0] pt2_s2 [DIM];
	logic signed [E_W-1:0]  e1_s2  [DIM];
	logic signed [E_W-1:0]  e2_s2  [DIM];

	e8d_d8 u_d8_int (
		.clk   (clk),
		.en    (en),
		.x     (x_int),
		.pt_s2 (pt1_s2),
		.e_s2  (e1_s2)
	);

	e8d_d8 u_d8_half (
		.clk   (clk),
		.en    (en),
		.x     (x_half),
		.pt_s2 (pt2_s2),
		.e_s2  (e2_s2)
	);

	logic [DS_W-1:0] d1_s4, d2_s4;

	e8d_dist u_dist_int (
		.clk     (clk),
		.en      (en),
		.e       (e1_s2),
		.dsum_s4 (d1_s4)
	);

	e8d_dist u_dist_half (
		.clk     (clk),
		.en      (en),
		.e       (e2_s2),
		.dsum_s4 (d2_s4)
	);

	// coordinates ride along with the distance stages; only the low bits
	// reach the output
	logic [LO_W-1:0] pt1_s3 [DIM];
	logic [LO_W-1:0] pt2_s3 [DIM];
	logic [LO_W-1:0] pt1_s4 [DIM];
	logic [LO_W-1:0] pt2_s4 [DIM];

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			for (int i = 0; i < DIM; i++) begin
				pt1_s3[i] <= pt1_s2[i][LO_W-1:0];
				pt2_s3[i] <= pt2_s2[i][LO_W-1:0];
			end
		end
		if (en.en_s4) begin
			for (int i = 0; i < DIM; i++) begin
				pt1_s4[i] <= pt1_s3[i];
				pt2_s4[i] <= pt2_s3[i];
			end
		end
	end

	// final stage: half-integer wins ties; doubled point is {p, 0} or {p, 1}
	logic                 half_c;
	logic [M_TDATA_W-1:0] tdata_c;
	logic [M_TDATA_W-1:0] tdata_s5;
	logic                 half_s5;

	always_comb begin
		half_c  = !(d1_s4 < d2_s4);
		tdata_c = '0;
		for (int i = 0; i < DIM; i++) begin
			tdata_c[OUT_W*i +: OUT_W] = half_c ? {pt2_s4[i], 1'b1} : {pt1_s4[i], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s5) begin
			tdata_s5 <= tdata_c;
			half_s5  <= half_c;
		end
	end

	assign m_tvalid = vld_s5;
	assign m_tdata  = tdata_s5;
	assign m_tuser  = half_s5;

	// checks: D8 parity after the fix, coset marks in the output
	logic odd1_s2, odd2_s2;
	logic [DIM-1:0] out_lsb;

	always_comb begin
		odd1_s2 = 1'b0;
		odd2_s2 = 1'b0;
		for (int i = 0; i < DIM; i++) begin
			odd1_s2    = odd1_s2 ^ pt1_s2[i][0];
			odd2_s2    = odd2_s2 ^ pt2_s2[i][0];
			out_lsb[i] = tdata_s5[OUT_W*i];
		end
	end

`ifndef ASSERT_OFF
	a_int_even: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> !odd1_s2)
		else $error("integer candidate has odd coordinate sum");

	a_half_even: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> !odd2_s2)
		else $error("half-integer candidate has odd coordinate sum");

	a_coset_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser ? (&out_lsb) : !(|out_lsb)))
		else $error("coordinate parity disagrees with coset flag");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5))
		else $error("input stalled with a bubble in the pipeline");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(vld_s4))
		else $error("output valid without a beat in the sum stage");
`endif

endmodule

>>> bench/tb_e8_lattice_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_e8_lattice_decoder_top
// Self-checking bench for the E8 nearest-point decoder. Vectors are fed from a
// queue by a bursty driver. Each accepted beat is decoded by a behavioral
// model in the bench. Output beats are compared field by field against the
// oldest pending point, while the receiver stalls on its own schedule.
// ----------------------------------------------------------------------------
module tb_e8_lattice_decoder_top;
	import e8d_pkg::*;

	localparam int RANDOM_VECTORS = 1350;
	localparam int IDLE_LIMIT     = 4000;   // cycles with no beat on either side
	localparam int HOLD_AT        = 400;    // input beats taken before the long stall
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 20;     // generous margin

	// expected output beat: pt2_0 .. pt2_7 packed as on m_tdata, plus coset flag
	typedef struct packed {
		logic [M_TDATA_W-1:0] pts;
		logic                 coset;
	} e8_point_t;

	typedef longint coord_vec_t [DIM];

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	logic [S_TDATA_W-1:0] pending_vectors [$];   // stimulus not yet accepted
	e8_point_t            pending_points  [$];   // decoded points not yet seen
	logic                 y_taken      = 1'b0;   // input beat accepted at last edge
	int                   vectors_total = 0;
	int                   vectors_taken = 0;
	int                   mismatches    = 0;
	int                   idle_cycles   = 0;
	int unsigned          cycle_no      = 0;

	e8_lattice_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // y_0 .. y_7
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // pt2_0 .. pt2_7
		.m_tuser  (m_tuser)     // half_coset
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Behavioral model
	// ------------------------------------------------------------------------

	// D8 decode in Q(FRAC_BITS): round half away from zero, then fix parity by
	// pushing the worst-rounded coordinate (lowest index on a tie) the other way
	function automatic void d8_nearest(input coord_vec_t x, output coord_vec_t pt);
		longint mag;
		longint err;
		longint worst_err;
		longint parity;
		int     worst;
		worst_err = -1;
		worst     = 0;
		parity    = 0;
		for (int i = 0; i < DIM; i++) begin
			mag   = (x[i] < 0) ? -x[i] : x[i];
			pt[i] = (mag + HALF_Q) >> FRAC_BITS;
			if (x[i] < 0)
				pt[i] = -pt[i];
			parity += pt[i];
			err = pt[i] * ONE_Q - x[i];
			if (err < 0)
				err = -err;
			if (err > worst_err) begin
				worst_err = err;
				worst     = i;
			end
		end
		if (parity[0]) begin
			// strictly above the rounded value moves up, anything else down
			if (x[worst] > pt[worst] * ONE_Q)
				pt[worst] += 1;
			else
				pt[worst] -= 1;
		end
	endfunction

	function automatic e8_point_t nearest_e8_point(input logic [S_TDATA_W-1:0] y_bus);
		coord_vec_t y;
		coord_vec_t y_shift;
		coord_vec_t p_int;
		coord_vec_t p_half;
		longint     dist_int;
		longint     dist_half;
		longint     e_int;
		longint     e_half;
		longint     v;
		e8_point_t  r;
		dist_int  = 0;
		dist_half = 0;
		for (int i = 0; i < DIM; i++) begin
			y[i]       = $signed(y_bus[i*IN_W +: IN_W]);
			y_shift[i] = y[i] - HALF_Q;
		end
		d8_nearest(y, p_int);
		d8_nearest(y_shift, p_half);
		// distances in half units times HALF_Q keep everything exact
		for (int i = 0; i < DIM; i++) begin
			e_int      = 2 * p_int[i] * HALF_Q - y[i];
			e_half     = (2 * p_half[i] + 1) * HALF_Q - y[i];
			dist_int  += e_int * e_int;
			dist_half += e_half * e_half;
		end
		// equal distance goes to the half-integer coset
		r.coset = !(dist_int < dist_half);
		for (int i = 0; i < DIM; i++) begin
			v = r.coset ? 2 * p_half[i] + 1 : 2 * p_int[i];
			r.pts[i*OUT_W +: OUT_W] = v[OUT_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [S_TDATA_W-1:0] vec(input int c0, input int c1, input int c2,
			input int c3, input int c4, input int c5, input int c6, input int c7);
		logic [S_TDATA_W-1:0] w;
		w = {c7[IN_W-1:0], c6[IN_W-1:0], c5[IN_W-1:0], c4[IN_W-1:0],
		     c3[IN_W-1:0], c2[IN_W-1:0], c1[IN_W-1:0], c0[IN_W-1:0]};
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// Driver: bursts of random length, random gaps, and a recurring gap-free
	// stretch. A presented beat is held until it is taken.
	// ------------------------------------------------------------------------
	int tx_burst_left = 0;
	int tx_gap_left   = 0;

	always @(negedge clk) begin
		logic                 nxt_valid;
		logic [S_TDATA_W-1:0] nxt_data;
		nxt_valid = 1'b0;
		nxt_data  = s_tdata;
		if (arst_n) begin
			if (y_taken)
				void'(pending_vectors.pop_front());
			if (s_tvalid && !y_taken) begin
				nxt_valid = 1'b1;
			end else if (tx_gap_left != 0) begin
				tx_gap_left--;
			end else begin
				nxt_valid = pending_vectors.size() != 0;
				if (nxt_valid)
					nxt_data = pending_vectors[0];
				if (tx_burst_left <= 1) begin
					tx_burst_left = $urandom_range(1, 32);
					if (cycle_no[8:7] == 2'd0 || $urandom_range(0, 3) == 0)
						tx_gap_left = 0;
					else
						tx_gap_left = $urandom_range(1, 8);
				end else begin
					tx_burst_left--;
				end
			end
		end
		s_tvalid <= nxt_valid;
		s_tdata  <= nxt_data;
	end

	// ------------------------------------------------------------------------
	// Receiver: pattern cycles through always-ready, mostly-ready, mostly-
	// stalled and a fixed duty cycle. One long hold-off lets the pipe fill
	// and back-pressure s_tready.
	// ------------------------------------------------------------------------
	int rx_hold_left = 0;
	bit rx_hold_done = 1'b0;

	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b0;
		if (arst_n) begin
			if (!rx_hold_done && vectors_taken >= HOLD_AT) begin
				rx_hold_done = 1'b1;
				rx_hold_left = HOLD_CYCLES;
			end
			if (rx_hold_left != 0) begin
				rx_hold_left--;
			end else begin
				case (cycle_no[9:8])
					2'd0: rdy = 1'b1;
					2'd1: rdy = $urandom_range(0, 9) < 7;
					2'd2: rdy = $urandom_range(0, 3) == 0;
					default: rdy = cycle_no[3:0] >= 4'd5;
				endcase
			end
		end
		m_tready <= rdy;
	end

	// ------------------------------------------------------------------------
	// Monitor: predict on input beats, check output beats, watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		e8_point_t want;
		cycle_no++;
		if (arst_n) begin
			y_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				pending_points.push_back(nearest_e8_point(s_tdata));
				vectors_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (pending_points.size() == 0) begin
					$display("%0t: output beat with nothing pending, tdata %h tuser %b",
					         $time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = pending_points.pop_front();
					for (int i = 0; i < DIM; i++) begin
						if (m_tdata[i*OUT_W +: OUT_W] !== want.pts[i*OUT_W +: OUT_W]) begin
							$display("%0t: pt2_%0d expected %0d, got %0d", $time, i,
							         $signed(want.pts[i*OUT_W +: OUT_W]),
							         $signed(m_tdata[i*OUT_W +: OUT_W]));
							mismatches++;
						end
					end
					if (m_tuser !== want.coset) begin
						$display("%0t: half_coset expected %b, got %b",
						         $time, want.coset, m_tuser);
						mismatches++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("e8_lattice_decoder_top regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		logic [S_TDATA_W-1:0] w;
		int                   kind;
		int                   c;
		int                   h;
		int                   one;

		h   = HALF_Q;
		one = ONE_Q;

		// extremes
		pending_vectors.push_back(vec(0, 0, 0, 0, 0, 0, 0, 0));
		pending_vectors.push_back(vec(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		pending_vectors.push_back(vec(-32768, -32768, -32768, -32768,
		                              -32768, -32768, -32768, -32768));
		pending_vectors.push_back(vec(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768));
		pending_vectors.push_back(vec(-32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		pending_vectors.push_back(vec(-1, -1, -1, -1, -1, -1, -1, -1));
		// exact half rounded away, odd sum, pulled back toward zero
		pending_vectors.push_back(vec(h, 0, 0, 0, 0, 0, 0, 0));
		pending_vectors.push_back(vec(-h, 0, 0, 0, 0, 0, 0, 0));
		// parity fix upward and downward
		pending_vectors.push_back(vec(one + 102, 0, 0, 0, 0, 0, 0, 0));
		pending_vectors.push_back(vec(154, 0, 0, 0, 0, 0, 0, 0));
		pending_vectors.push_back(vec(-one - 102, 0, 0, 0, 0, 0, 0, 0));
		// equal rounding errors, lowest index takes the fix
		pending_vectors.push_back(vec(one + 77, 77, 0, 0, 0, 0, 0, 0));
		pending_vectors.push_back(vec(0, 0, 0, 77, 0, 77, -77, one + 77));
		// equal distance to both candidates
		pending_vectors.push_back(vec(h/2, h/2, h/2, h/2, h/2, h/2, h/2, h/2));
		pending_vectors.push_back(vec(-h/2, -h/2, -h/2, -h/2, -h/2, -h/2, -h/2, -h/2));
		// exact half-integer point, and one needing a fix in the shifted decode
		pending_vectors.push_back(vec(h, h, h, h, h, h, h, h));
		pending_vectors.push_back(vec(-h, -h, -h, -h, -h, -h, -h, -h));
		pending_vectors.push_back(vec(h, h, h, h, h, h, h, one));
		// exact integer lattice points, then one with coordinates at and around +/-h
		pending_vectors.push_back(vec(one, one, 0, 0, 0, 0, 0, 0));
		pending_vectors.push_back(vec(-2*one, one, -one, 0, 3*one, 0, -one, 0));
		pending_vectors.push_back(vec(h - 1, h + 1, -h + 1, -h - 1, 1, -1, h, -h));

		for (int n = 0; n < RANDOM_VECTORS; n++) begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < DIM; i++) begin
				case (kind)
					0, 1, 2: c = $urandom_range(0, 65535);
					// near half-lattice points: hits halves, ties and parity fixes
					3, 4, 5, 6: c = (int'($urandom_range(0, 32)) - 16) * h
					                + int'($urandom_range(0, 6)) - 3;
					7, 8: c = int'($urandom_range(0, 4 * one)) - 2 * one;
					default: begin
						case ($urandom_range(0, 3))
							0: c = -32768;
							1: c = 32767;
							2: c = -32768 + int'($urandom_range(0, 300));
							default: c = 32767 - int'($urandom_range(0, 300));
						endcase
					end
				endcase
				w[i*IN_W +: IN_W] = c[IN_W-1:0];
			end
			pending_vectors.push_back(w);
		end
		vectors_total = pending_vectors.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (vectors_taken < vectors_total || pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("e8_lattice_decoder_top regression: pass");
		else
			$display("e8_lattice_decoder_top regression: fail");
		$finish;
	end

endmodule
